// File: rtl/core/fdf_pkg.sv
package fdf_pkg;

   localparam int FRAME_WORDS_DEF        = 117;
   localparam int CHANNELS_PER_BLOCK_DEF = 128;
   localparam int ALIGN_SLACK_DEF        = 16;

   localparam int DATA_START   = 4;
   localparam int BLOCK_WORDS  = 56;
   localparam int DATA_END     = DATA_START + 2 * BLOCK_WORDS;
   localparam int SAMPLE_W     = 14;
   localparam int RES_SLOTS    = 3;

   localparam logic [15:0] FPE_RESET = 16'd2000;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic CSR_START_TS       = 1'b0;
   localparam logic CSR_FRAMES_PER_EVT = 1'b1;

   typedef struct packed {
      logic [63:0] start_timestamp;
      logic [15:0] frames_per_event;
   } cfg_type;

   typedef struct packed {
      logic [6:0]  word_index;
      logic [12:0] bit_carry;
      logic [3:0]  carry_count;
      logic [8:0]  channel_count;
      logic [31:0] time_low;
      logic [2:0]  latched_slot;
      logic        latched_fiber;
      logic [15:0] frame_count;
      logic        started;
      logic        dropping;
   } state_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [7:0]          channel;
      logic [SAMPLE_W-1:0] sample_value;
      logic [2:0]          slot_id;
      logic                fiber_id;
      logic [63:0]         frame_time;
      logic                last;
   } rsp_item_type;

endpackage

// File: rtl/core/fdf_if.sv
interface fdf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic        frame_first;

   modport source(output valid, output data_word, output frame_first, input ready);
   modport sink(input valid, input data_word, input frame_first, output ready);
endinterface

interface fdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  channel;
   logic [13:0] sample_value;
   logic [2:0]  slot_id;
   logic        fiber_id;
   logic [63:0] frame_time;
   logic        last;

   modport source(output valid, output kind, output channel, output sample_value,
                  output slot_id, output fiber_id, output frame_time, output last,
                  input ready);
   modport sink(input valid, input kind, input channel, input sample_value,
                input slot_id, input fiber_id, input frame_time, input last,
                output ready);
endinterface

interface fdf_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [63:0] wdata;

   modport source(output valid, output index, output wdata, input ready);
   modport sink(input valid, input index, input wdata, output ready);
endinterface

// File: rtl/core/fdf_unpack.sv
module fdf_unpack #(
   parameter int FRAME_WORDS        = fdf_pkg::FRAME_WORDS_DEF,
   parameter int CHANNELS_PER_BLOCK = fdf_pkg::CHANNELS_PER_BLOCK_DEF,
   parameter int ALIGN_SLACK        = fdf_pkg::ALIGN_SLACK_DEF
) (
   input  fdf_pkg::state_type    st_cur,
   input  fdf_pkg::cfg_type      cfg,
   input  logic [31:0]           data_word,
   input  logic                  frame_first,
   output fdf_pkg::state_type    st_nxt,
   output fdf_pkg::rsp_item_type res [fdf_pkg::RES_SLOTS],
   output logic [1:0]            res_count
);
   import fdf_pkg::*;

   localparam logic [6:0]  LAST_WORD = 7'(FRAME_WORDS - 1);
   localparam logic [63:0] SLACK     = 64'(ALIGN_SLACK);
   localparam logic [7:0]  CPB       = 8'(CHANNELS_PER_BLOCK);
   localparam logic [6:0]  CPB_LAST  = 7'(CHANNELS_PER_BLOCK - 1);

   logic [6:0]   idx;
   logic         is_data;
   logic         blk_start;
   logic [12:0]  carry_b;
   logic [3:0]   cc_b;
   logic [8:0]   chan_b;
   logic [44:0]  acc;
   logic [5:0]   avail;
   logic [5:0]   avail_m;
   logic         three;
   logic [2:0]   cs;
   logic         cf;
   logic         mismatch;
   logic [63:0]  ts;
   logic         early;
   logic [16:0]  fc_inc;
   logic         fc_wrap;
   logic [2:0]   emit;
   logic [2:0]   trig;
   logic [8:0]   pos [RES_SLOTS];
   rsp_item_type cand [RES_SLOTS];
   rsp_item_type one_res;

   always_comb begin
      idx       = frame_first ? 7'd0 : st_cur.word_index;
      is_data   = (idx >= 7'(DATA_START)) && (idx < 7'(DATA_END));
      blk_start = (idx == 7'(DATA_START)) || (idx == 7'(DATA_START + BLOCK_WORDS));
      carry_b   = blk_start ? 13'd0 : st_cur.bit_carry;
      cc_b      = blk_start ? 4'd0 : st_cur.carry_count;
      chan_b    = (idx == 7'(DATA_START)) ? 9'd0 : st_cur.channel_count;
      acc       = {32'd0, carry_b} | ({13'd0, data_word} << cc_b);
      avail     = {2'd0, cc_b} + 6'd32;
      three     = avail >= 6'd42;
      avail_m   = avail - (three ? 6'd42 : 6'd28);

      cs       = data_word[14:12];
      cf       = data_word[15];
      mismatch = (cs != st_cur.latched_slot) || (cf != st_cur.latched_fiber);
      ts       = {data_word, st_cur.time_low};
      early    = !st_cur.started && (cfg.start_timestamp > SLACK)
                 && (ts < cfg.start_timestamp - SLACK);

      fc_inc  = {1'b0, st_cur.frame_count} + 17'd1;
      fc_wrap = fc_inc >= {1'b0, cfg.frames_per_event};

      for (int k = 0; k < RES_SLOTS; k++) begin
         pos[k]  = chan_b + 9'(k);
         emit[k] = ((k < 2) || three) && !pos[k][8]
                   && ({1'b0, pos[k][6:0]} < CPB);
         trig[k] = emit[k] && pos[k][7] && (pos[k][6:0] == CPB_LAST);
         cand[k].kind         = KIND_SAMPLE;
         cand[k].channel      = pos[k][7] ? CPB + {1'b0, pos[k][6:0]}
                                          : {1'b0, pos[k][6:0]};
         cand[k].sample_value = acc[SAMPLE_W*k +: SAMPLE_W];
         cand[k].slot_id      = st_cur.latched_slot;
         cand[k].fiber_id     = st_cur.latched_fiber;
         cand[k].frame_time   = 64'd0;
         cand[k].last         = trig[k] && fc_wrap;
      end

      one_res.kind         = KIND_HEADER;
      one_res.channel      = 8'd0;
      one_res.sample_value = '0;
      one_res.slot_id      = st_cur.latched_slot;
      one_res.fiber_id     = st_cur.latched_fiber;
      one_res.frame_time   = ts;
      one_res.last         = 1'b0;

      st_nxt            = st_cur;
      st_nxt.word_index = ({1'b0, idx} + 8'd1 >= {1'b0, LAST_WORD} + 8'd1) ? 7'd0
                                                                          : idx + 7'd1;
      res[0]    = cand[0];
      res[1]    = cand[1];
      res[2]    = cand[2];
      res_count = 2'd0;

      if (idx == 7'd0) begin
         st_nxt.dropping = 1'b0;
         if (st_cur.frame_count == 16'd0) begin
            st_nxt.latched_slot  = cs;
            st_nxt.latched_fiber = cf;
         end else if (mismatch) begin
            st_nxt.dropping      = 1'b1;
            one_res.kind         = KIND_ERROR;
            one_res.slot_id      = cs;
            one_res.fiber_id     = cf;
            one_res.frame_time   = 64'd0;
            res[0]               = one_res;
            res_count            = 2'd1;
         end
      end else if (st_cur.dropping) begin
         st_nxt.dropping = 1'b1;
      end else if (idx == 7'd2) begin
         st_nxt.time_low = data_word;
      end else if (idx == 7'd3) begin
         if (early) begin
            st_nxt.dropping = 1'b1;
         end else begin
            st_nxt.started = 1'b1;
            res[0]         = one_res;
            res_count      = 2'd1;
         end
      end else if (is_data) begin
         st_nxt.bit_carry     = three ? {10'd0, acc[44:42]} : acc[40:28];
         st_nxt.carry_count   = avail_m[3:0];
         st_nxt.channel_count = chan_b + (three ? 9'd3 : 9'd2);
         if (trig != 3'd0) begin
            st_nxt.frame_count = fc_wrap ? 16'd0 : fc_inc[15:0];
         end
         res[0]    = emit[0] ? cand[0] : (emit[1] ? cand[1] : cand[2]);
         res[1]    = (emit[0] && emit[1]) ? cand[1] : cand[2];
         res[2]    = cand[2];
         res_count = 2'({1'b0, emit[0]} + {1'b0, emit[1]} + {1'b0, emit[2]});
      end
   end

endmodule

// File: rtl/core/frame_deframer_14bit_unpack.sv
// frame deframer with 14-bit sample unpacking
// req_bus: one 32-bit stream word per beat; frame_first marks word 0 of a frame
// and resynchronizes the word counter, otherwise the counter wraps by itself.
// rsp_bus: one result per beat: a sample with its channel, a frame header at
// word 3 carrying the 64-bit timestamp, or a slot/fiber mismatch error.
// csr_bus: register writes (index 0 start timestamp, index 1 frames per event),
// always ready, to be used only while no word is in flight.
// an accepted word is unpacked into the result register once that is free; the
// input register takes a word every cycle while the result register is free.
// each word becomes up to three results in one pass, parked in a three-entry
// result register that drains one beat per cycle while rsp ready is high, so
// a data word holds the input until drained; header words pass one per cycle.
// reset clears the frame state, the pipeline and the registers to their
// defaults (start timestamp 0, 2000 frames per event).
// a stalled receiver holds the current result; the input register keeps its
// word and req ready drops until the result register frees up.
module frame_deframer_14bit_unpack #(
   parameter int FRAME_WORDS        = fdf_pkg::FRAME_WORDS_DEF,
   parameter int CHANNELS_PER_BLOCK = fdf_pkg::CHANNELS_PER_BLOCK_DEF,
   parameter int ALIGN_SLACK        = fdf_pkg::ALIGN_SLACK_DEF
) (
   input logic      clock,
   input logic      reset,
   fdf_req_if.sink  req_bus,
   fdf_rsp_if.source rsp_bus,
   fdf_csr_if.sink  csr_bus
);
   import fdf_pkg::*;

   cfg_type      cfg_ff;
   state_type    st_ff;
   state_type    st_in;
   logic         s1_valid_ff;
   logic [31:0]  s1_word_ff;
   logic         s1_first_ff;
   rsp_item_type grp_ff [RES_SLOTS];
   rsp_item_type grp_in [RES_SLOTS];
   logic [1:0]   grp_cnt_in;
   logic [1:0]   rem_ff;
   logic [1:0]   ptr_ff;
   logic         grp_free;
   logic         grp_load;
   logic         take;
   logic         req_acc;
   rsp_item_type cur;

   fdf_unpack #(
      .FRAME_WORDS        (FRAME_WORDS),
      .CHANNELS_PER_BLOCK (CHANNELS_PER_BLOCK),
      .ALIGN_SLACK        (ALIGN_SLACK)
   ) u_unpack (
      .st_cur      (st_ff),
      .cfg         (cfg_ff),
      .data_word   (s1_word_ff),
      .frame_first (s1_first_ff),
      .st_nxt      (st_in),
      .res         (grp_in),
      .res_count   (grp_cnt_in)
   );

   assign take     = (rem_ff != 2'd0) && rsp_bus.ready;
   assign grp_free = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_bus.ready);
   assign grp_load = s1_valid_ff && grp_free;
   assign req_acc  = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !s1_valid_ff || grp_free;
   assign csr_bus.ready = 1'b1;

   assign cur                  = grp_ff[ptr_ff];
   assign rsp_bus.valid        = rem_ff != 2'd0;
   assign rsp_bus.kind         = cur.kind;
   assign rsp_bus.channel      = cur.channel;
   assign rsp_bus.sample_value = cur.sample_value;
   assign rsp_bus.slot_id      = cur.slot_id;
   assign rsp_bus.fiber_id     = cur.fiber_id;
   assign rsp_bus.frame_time   = cur.frame_time;
   assign rsp_bus.last         = cur.last;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_timestamp  <= 64'd0;
         cfg_ff.frames_per_event <= FPE_RESET;
         st_ff                   <= '0;
         s1_valid_ff             <= 1'b0;
         rem_ff                  <= 2'd0;
         ptr_ff                  <= 2'd0;
      end else begin
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               CSR_START_TS:       cfg_ff.start_timestamp  <= csr_bus.wdata;
               CSR_FRAMES_PER_EVT: cfg_ff.frames_per_event <= csr_bus.wdata[15:0];
               default:            cfg_ff <= cfg_ff;
            endcase
         end
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (grp_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (grp_load) begin
            st_ff  <= st_in;
            rem_ff <= grp_cnt_in;
            ptr_ff <= 2'd0;
         end else if (take) begin
            rem_ff <= rem_ff - 2'd1;
            ptr_ff <= ptr_ff + 2'd1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_word_ff  <= req_bus.data_word;
         s1_first_ff <= req_bus.frame_first;
      end
      if (grp_load) begin
         grp_ff <= grp_in;
      end
   end

endmodule

// File: rtl/core/fdf_checker.sv
module fdf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  kind,
   input logic [7:0]  channel,
   input logic [13:0] sample_value,
   input logic [63:0] frame_time,
   input logic        last
);
   import fdf_pkg::*;

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(channel)
         && $stable(sample_value) && $stable(frame_time) && $stable(last))
      else $error("rsp beat changed while stalled");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (kind == KIND_SAMPLE) || (kind == KIND_HEADER) || (kind == KIND_ERROR))
      else $error("rsp kind out of range");

   a_last_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last |-> kind == KIND_SAMPLE)
      else $error("last on a non-sample beat");

   a_nonsample_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (kind != KIND_SAMPLE) |-> (channel == 8'd0) && (sample_value == 14'd0))
      else $error("header or error beat carries sample data");

   a_sample_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (kind == KIND_SAMPLE) |-> frame_time == 64'd0)
      else $error("sample beat carries a timestamp");

endmodule

bind frame_deframer_14bit_unpack fdf_checker u_fdf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .kind         (rsp_bus.kind),
   .channel      (rsp_bus.channel),
   .sample_value (rsp_bus.sample_value),
   .frame_time   (rsp_bus.frame_time),
   .last         (rsp_bus.last)
);
